@@ hdl/vdl_pkg.sv @@
// Shared types for the variable sample delay line.
package vdl_pkg;

    typedef enum logic [1:0] {
        SRC_PASS,
        SRC_MEM,
        SRC_ZERO
    } src_t;

endpackage

@@ hdl/variable_sample_delay_line_top.sv @@
// Top level of the variable sample delay line.
//
// Each sample transferred on the input channel (in_valid, in_stall, sample_in) produces
// one sample on the output channel (out_valid, out_stall, sample_out): the sample that
// entered delay_length transfers earlier, or zero while the history since the last
// clear does not yet reach that far back. A delay of zero passes the sample through.
// The user must write the delay on the configuration channel (cfg_valid, cfg_ready,
// delay_length) only while the block is idle; the block does not enforce this. Values
// above MAX_DELAY are ignored; a larger delay than the current one clears the history.
// An accepted sample passes through the stage register and then the output register.
// One sample is accepted every cycle while in_stall is low: the store is a dual-port RAM
// written and read once per sample, and a stage between the RAM read and the output
// register lets a new sample enter while a result waits. When the receiver stalls, the
// output register and the stage behind it fill; in_stall rises only when both are full.
// Reset clears the delay, the write pointer and the fill count; the RAM is not
// cleared, as the fill count keeps unwritten entries from ever being output.
module variable_sample_delay_line_top
    import vdl_pkg::*;
#(
    parameter int MAX_DELAY   = 8192,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [SAMPLE_BITS-1:0]              sample_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [$clog2(MAX_DELAY+1)-1:0]      delay_length
);

    localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DLW = $clog2(MAX_DELAY + 1);
    localparam int SW  = DLW + 1;

    logic [DLW-1:0]         delay_reg, delay_next;
    logic [DLW-1:0]         fill_reg, fill_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic                   s1_valid_reg, s1_valid_next;
    src_t                   s1_src_reg;
    logic [SAMPLE_BITS-1:0] s1_pass_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    logic                   accept;
    logic                   s1_adv;
    logic                   cfg_wr;
    logic [SW-1:0]          wp_w;
    logic [SW-1:0]          dl_w;
    logic [SW-1:0]          rd_w;
    logic [AW-1:0]          rd_addr;
    src_t                   src;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] result;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        wp_w = SW'(wp_reg);
        dl_w = SW'(delay_reg);
        if (wp_w >= dl_w)
        begin
            rd_w = wp_w - dl_w;
        end
        else
        begin
            rd_w = wp_w + SW'(MAX_DELAY) - dl_w;
        end
        rd_addr = rd_w[AW-1:0];
    end

    always_comb
    begin
        if (delay_reg == '0)
        begin
            src = SRC_PASS;
        end
        else if (fill_reg >= delay_reg)
        begin
            src = SRC_MEM;
        end
        else
        begin
            src = SRC_ZERO;
        end
    end

    vdl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (sample_in),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        delay_next = delay_reg;
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        if (accept)
        begin
            if (wp_reg == AW'(MAX_DELAY - 1))
            begin
                wp_next = '0;
            end
            else
            begin
                wp_next = wp_reg + AW'(1);
            end
            if (fill_reg < DLW'(MAX_DELAY))
            begin
                fill_next = fill_reg + DLW'(1);
            end
        end
        if (cfg_wr && (delay_length <= DLW'(MAX_DELAY)))
        begin
            if (delay_length > delay_reg)
            begin
                fill_next = '0;
            end
            delay_next = delay_length;
        end
    end

    always_comb
    begin
        case (s1_src_reg)
            SRC_PASS: result = s1_pass_reg;
            SRC_MEM:  result = rdata;
            default:  result = '0;
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            delay_reg     <= delay_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg  <= src;
            s1_pass_reg <= sample_in;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

@@ hdl/vdl_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module vdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the entry being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/vdl_checker.sv @@
// Port-level checker for the variable sample delay line and its bind statement.
module vdl_checker #(
    parameter int SAMPLE_BITS = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("stalled output transfer changed");

    // A new result appears only after the transfer that caused it has passed through the stage and output registers.
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output appeared without a matching input transfer");

    // With an empty output register the input side is never held off.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output register is empty");

    // The delay register can always be written.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind variable_sample_delay_line_top vdl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_vdl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
